// ----- rtl/mgpt_pkg.sv -----
// Shared types, constants and helper functions of the maneuver goal pose tracker.
// No dependencies; the CORDIC and top-level files use it by scoped names.
package mgpt_pkg;

  // CORDIC iteration count and the width of its step counter
  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

  // Angle constants, Q16.16, carried in the wide angle width
  localparam int ANG_W = 26;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 26'sd205887;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 26'sd411775;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 26'sd102944;

  // CORDIC datapath width and start gain, Q2.30
  localparam int CW = 34;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  typedef enum logic [2:0] {
    OP_SET_GLOBAL,
    OP_SET_LOCAL,
    OP_PASSED,
    OP_ALIGNED,
    OP_PARALLEL,
    OP_LOCAL_FRAME,
    OP_JUMP,
    OP_SHIFT
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_FINISH,
    ST_OUTPUT
  } seq_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_REDUCE,
    CS_FOLD,
    CS_ITER
  } cordic_state_t;

  // Sequencer to CORDIC request and response
  typedef struct packed {
    logic              start;
    logic signed [22:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cordic_rsp_t;

  // Arctangent of 2^-i, Q2.30
  function automatic logic signed [CW-1:0] atan_step(input logic [4:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd31: r = '0;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  // One wrap toward 0..2pi
  function automatic logic signed [ANG_W-1:0] wrap_once(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    if (a > ANG_TWO_PI) r = a - ANG_TWO_PI;
    else if (a < 0)     r = a + ANG_TWO_PI;
    else                r = a;
    return r;
  endfunction

  // Smallest difference of two headings
  function automatic logic signed [ANG_W-1:0] heading_diff(input logic signed [ANG_W-1:0] a,
                                                           input logic signed [ANG_W-1:0] b);
    logic signed [ANG_W-1:0] d;
    d = wrap_once(a) - wrap_once(b);
    if (d < 0) d = -d;
    if (d > ANG_PI) begin
      d = ANG_TWO_PI - d;
      if (d < 0) d = -d;
    end
    return d;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v < -40'sd2147483648)     r = 32'sh8000_0000;
    else if (v > 40'sd2147483647) r = 32'sh7fff_ffff;
    else                          r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [20:0] sat21(input logic signed [23:0] v);
    logic signed [20:0] r;
    if (v < -24'sd1048576)     r = 21'sh10_0000;
    else if (v > 24'sd1048575) r = 21'sh0f_ffff;
    else                       r = v[20:0];
    return r;
  endfunction

endpackage

// ----- rtl/mgpt_mulq.sv -----
// Shared multiplier: Q16.16 value times Q2.30 factor, rounded to Q16.16.
// Does not use mgpt_pkg; no submodules.
module mgpt_mulq (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [31:0] b,
  output logic signed [34:0] prod
);

  logic signed [64:0] full;
  logic signed [64:0] rounded;

  // round half up, then floor shift by 30
  always_comb begin
    full    = 65'(a) * 65'(b);
    rounded = (full + 65'sd536870912) >>> 30;
  end

  always_ff @(posedge clk) begin
    prod <= rounded[34:0];
  end

endmodule

// ----- rtl/mgpt_cordic.sv -----
// Iterative CORDIC: angle reduction, quadrant fold and one rotation step a cycle.
// Depends on mgpt_pkg.
module mgpt_cordic (
  input  logic                     clk,
  input  logic                     rst,
  input  mgpt_pkg::cordic_req_t    req,
  output mgpt_pkg::cordic_rsp_t    rsp
);

  mgpt_pkg::cordic_state_t state, state_next;
  logic signed [mgpt_pkg::ANG_W-1:0] ang, ang_next;
  logic signed [mgpt_pkg::CW-1:0] x, y, z, x_next, y_next, z_next;
  logic neg, neg_next;
  logic [mgpt_pkg::CNT_W-1:0] cnt, cnt_next;

  logic signed [mgpt_pkg::ANG_W-1:0] b0, b1;
  logic signed [mgpt_pkg::CW-1:0] xs, ys, at;
  logic f_neg;
  logic last;

  assign last = (cnt == mgpt_pkg::CNT_W'(mgpt_pkg::CORDIC_STEPS));

  always_ff @(posedge clk) begin
    if (rst) state <= mgpt_pkg::CS_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    ang <= ang_next;
    x   <= x_next;
    y   <= y_next;
    z   <= z_next;
    neg <= neg_next;
    cnt <= cnt_next;
  end

  // next state and datapath
  always_comb begin
    state_next = state;
    ang_next = ang;
    x_next = x;
    y_next = y;
    z_next = z;
    neg_next = neg;
    cnt_next = cnt;
    // fold into -pi..pi, then into -pi/2..pi/2
    if (ang > mgpt_pkg::ANG_PI)       b0 = ang - mgpt_pkg::ANG_TWO_PI;
    else if (ang < -mgpt_pkg::ANG_PI) b0 = ang + mgpt_pkg::ANG_TWO_PI;
    else                              b0 = ang;
    f_neg = 1'b0;
    if (b0 > mgpt_pkg::ANG_HALF_PI) begin
      b1 = b0 - mgpt_pkg::ANG_PI;
      f_neg = 1'b1;
    end else if (b0 < -mgpt_pkg::ANG_HALF_PI) begin
      b1 = b0 + mgpt_pkg::ANG_PI;
      f_neg = 1'b1;
    end else begin
      b1 = b0;
    end
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = mgpt_pkg::atan_step(5'(cnt));
    unique case (state)
      mgpt_pkg::CS_IDLE: begin
        if (req.start) begin
          ang_next = mgpt_pkg::ANG_W'(req.angle);
          state_next = mgpt_pkg::CS_REDUCE;
        end
      end
      mgpt_pkg::CS_REDUCE: begin
        // truncating remainder by 2pi
        if (ang >= mgpt_pkg::ANG_TWO_PI)       ang_next = ang - mgpt_pkg::ANG_TWO_PI;
        else if (ang <= -mgpt_pkg::ANG_TWO_PI) ang_next = ang + mgpt_pkg::ANG_TWO_PI;
        else                                   state_next = mgpt_pkg::CS_FOLD;
      end
      mgpt_pkg::CS_FOLD: begin
        z_next = mgpt_pkg::CW'(b1) <<< 14;
        x_next = mgpt_pkg::GAIN_Q30;
        y_next = '0;
        neg_next = f_neg;
        cnt_next = '0;
        state_next = mgpt_pkg::CS_ITER;
      end
      mgpt_pkg::CS_ITER: begin
        if (last) begin
          state_next = mgpt_pkg::CS_IDLE;
        end else begin
          if (z >= 0) begin
            x_next = x - ys;
            y_next = y + xs;
            z_next = z - at;
          end else begin
            x_next = x + ys;
            y_next = y - xs;
            z_next = z + at;
          end
          cnt_next = cnt + 1'b1;
        end
      end
      default: state_next = mgpt_pkg::CS_IDLE;
    endcase
  end

  // result valid in the cycle after the last step
  always_comb begin
    rsp.done  = (state == mgpt_pkg::CS_ITER) && last;
    rsp.cos_v = neg ? 32'(-x) : 32'(x);
    rsp.sin_v = neg ? 32'(-y) : 32'(y);
  end

endmodule

// ----- rtl/maneuver_goal_pose_tracker.sv -----
// Top level of the maneuver goal pose tracker: goal state, sequencer, result register.
// Depends on mgpt_pkg, mgpt_cordic and mgpt_mulq.
//
// Usage:
// One input channel (in_valid / in_stall) takes a request: opcode, current pose and
// operands. One output channel (out_valid / out_stall) returns one result per request:
// a flag, the goal pose (global, or vehicle frame for the local-frame opcode) and the
// active flag after the request.
// Requests are handled one at a time; in_stall is high from acceptance until the result
// has been taken. Opcodes without trig pass through the finish state to the output state,
// which raises out_valid. Opcodes with sine/cosine run the shared CORDIC (reduction by
// 2pi, quadrant fold, CORDIC_STEPS rotation steps, done), then the shared multiplier
// (2 or 4 products plus a drain step) and the finish state before the output state.
// A new request is taken only once the result has been taken and the sequencer is idle.
// Reset clears the goal (inactive, owner 0, pose 0) and drops out_valid. While out_stall
// is high the result holds and no new request is accepted.
module maneuver_goal_pose_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] pose_x,
  input  logic signed [31:0] pose_y,
  input  logic signed [20:0] pose_heading,
  input  logic signed [31:0] arg_x,
  input  logic signed [31:0] arg_y,
  input  logic signed [20:0] arg_angle,
  input  logic [15:0]        requester_id,
  input  logic               flipped,
  input  logic signed [31:0] dist_tolerance,
  input  logic [19:0]        angle_margin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               flag,
  output logic signed [31:0] goal_x,
  output logic signed [31:0] goal_y,
  output logic signed [20:0] goal_heading,
  output logic               active
);

  mgpt_pkg::seq_state_t state, state_next;

  // goal state
  logic               goal_active;
  logic [15:0]        owner_id;
  logic signed [31:0] goal_px, goal_py;
  logic signed [21:0] goal_angle;

  // latched request
  mgpt_pkg::op_t      op_r;
  logic signed [31:0] px_r, py_r, ax_r, ay_r, tol_r;
  logic signed [20:0] ph_r, aa_r;
  logic [15:0]        id_r;
  logic               flp_r;
  logic [19:0]        margin_r;
  logic               owned_r;
  logic signed [32:0] dx_r, dy_r;

  // trig and products
  logic signed [31:0] c_r, s_r;
  logic signed [34:0] p0, p1, p2, p3;
  logic [2:0]         k;
  logic [2:0]         nprod;

  mgpt_pkg::cordic_req_t creq;
  mgpt_pkg::cordic_rsp_t crsp;
  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic signed [34:0] prod;

  logic accept;
  logic owned_in;
  logic needs_trig;
  mgpt_pkg::op_t op_in;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != mgpt_pkg::ST_IDLE);
  assign out_valid = (state == mgpt_pkg::ST_OUTPUT);
  assign op_in    = mgpt_pkg::op_t'(opcode);
  assign owned_in = goal_active && (requester_id == owner_id);

  // which requests run the CORDIC
  always_comb begin
    unique case (op_in)
      mgpt_pkg::OP_SET_LOCAL:   needs_trig = !owned_in;
      mgpt_pkg::OP_PASSED:      needs_trig = goal_active;
      mgpt_pkg::OP_LOCAL_FRAME,
      mgpt_pkg::OP_SHIFT:       needs_trig = 1'b1;
      default:                  needs_trig = 1'b0;
    endcase
  end

  always_comb begin
    creq.start = accept && needs_trig;
    creq.angle = (op_in == mgpt_pkg::OP_SHIFT) ?
                 23'(goal_angle) + 23'(mgpt_pkg::ANG_HALF_PI) : 23'(pose_heading);
  end

  mgpt_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  // multiplier operand selection
  always_comb begin
    ma = 33'(ax_r);
    mb = c_r;
    unique case (op_r)
      mgpt_pkg::OP_SET_LOCAL: begin
        ma = (k[0] == 1'b0) ? 33'(ax_r) : 33'(ay_r);
        mb = (k[1:0] == 2'd0 || k[1:0] == 2'd3) ? c_r : s_r;
      end
      mgpt_pkg::OP_PASSED: begin
        ma = (k[0] == 1'b0) ? dx_r : dy_r;
        mb = (k[0] == 1'b0) ? c_r : s_r;
      end
      mgpt_pkg::OP_LOCAL_FRAME: begin
        ma = (k[1:0] == 2'd0 || k[1:0] == 2'd3) ? dx_r : dy_r;
        mb = (k[0] == 1'b0) ? c_r : s_r;
      end
      mgpt_pkg::OP_SHIFT: begin
        ma = 33'(ay_r);
        mb = (k[0] == 1'b0) ? c_r : s_r;
      end
      default: begin
        ma = 33'(ax_r);
        mb = c_r;
      end
    endcase
  end

  mgpt_mulq u_mulq (
    .clk  (clk),
    .a    (ma),
    .b    (mb),
    .prod (prod)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= mgpt_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mgpt_pkg::ST_IDLE:
        if (accept) state_next = needs_trig ? mgpt_pkg::ST_CORDIC : mgpt_pkg::ST_FINISH;
      mgpt_pkg::ST_CORDIC:
        if (crsp.done) state_next = mgpt_pkg::ST_MUL;
      mgpt_pkg::ST_MUL:
        if (k == nprod) state_next = mgpt_pkg::ST_FINISH;
      mgpt_pkg::ST_FINISH:
        state_next = mgpt_pkg::ST_OUTPUT;
      mgpt_pkg::ST_OUTPUT:
        if (!out_stall) state_next = mgpt_pkg::ST_IDLE;
      default: state_next = mgpt_pkg::ST_IDLE;
    endcase
  end

  // request latch, trig capture, product collection
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_in;
      px_r     <= pose_x;
      py_r     <= pose_y;
      ph_r     <= pose_heading;
      ax_r     <= arg_x;
      ay_r     <= arg_y;
      aa_r     <= arg_angle;
      id_r     <= requester_id;
      flp_r    <= flipped;
      tol_r    <= dist_tolerance;
      margin_r <= angle_margin;
      owned_r  <= owned_in;
      dx_r     <= 33'(goal_px) - 33'(pose_x);
      dy_r     <= 33'(goal_py) - 33'(pose_y);
      nprod    <= (op_in == mgpt_pkg::OP_SET_LOCAL || op_in == mgpt_pkg::OP_LOCAL_FRAME) ?
                  3'd4 : 3'd2;
    end
    if (state == mgpt_pkg::ST_CORDIC && crsp.done) begin
      c_r <= crsp.cos_v;
      s_r <= crsp.sin_v;
      k   <= '0;
    end
    if (state == mgpt_pkg::ST_MUL) begin
      k <= k + 1'b1;
      unique case (k)
        3'd1: p0 <= prod;
        3'd2: p1 <= prod;
        3'd3: p2 <= prod;
        3'd4: p3 <= prod;
        default: ;
      endcase
    end
  end

  // final arithmetic
  logic signed [mgpt_pkg::ANG_W-1:0] md_goal_ph, md_par;
  logic signed [mgpt_pkg::ANG_W-1:0] margin_w, pi_minus_margin;
  logic signed [36:0] proj, tol_w;
  logic dist_ok, ang_ok, passed;
  logic signed [21:0] wrap_set;

  always_comb begin
    md_goal_ph = mgpt_pkg::heading_diff(mgpt_pkg::ANG_W'(goal_angle), mgpt_pkg::ANG_W'(ph_r));
    md_par = mgpt_pkg::heading_diff(mgpt_pkg::ANG_W'(aa_r) + mgpt_pkg::ANG_W'(ph_r),
                                    mgpt_pkg::ANG_W'(goal_angle));
    margin_w = mgpt_pkg::ANG_W'({1'b0, margin_r});
    pi_minus_margin = mgpt_pkg::ANG_PI - margin_w;
    proj  = 37'(p0) + 37'(p1);
    tol_w = 37'(tol_r);
    if (flp_r) begin
      dist_ok = proj > -tol_w;
      ang_ok  = md_goal_ph > pi_minus_margin;
    end else begin
      dist_ok = proj < tol_w;
      ang_ok  = md_goal_ph < margin_w;
    end
    passed = goal_active && dist_ok && ang_ok;
    if (op_r == mgpt_pkg::OP_SET_GLOBAL)
      wrap_set = 22'(mgpt_pkg::wrap_once(mgpt_pkg::ANG_W'(aa_r)));
    else
      wrap_set = 22'(mgpt_pkg::wrap_once(mgpt_pkg::ANG_W'(ph_r) + mgpt_pkg::ANG_W'(aa_r)));
  end

  // goal update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_active <= 1'b0;
      owner_id    <= '0;
      goal_px     <= '0;
      goal_py     <= '0;
      goal_angle  <= '0;
    end else if (state == mgpt_pkg::ST_FINISH) begin
      flag         <= 1'b0;
      goal_x       <= goal_px;
      goal_y       <= goal_py;
      goal_heading <= goal_angle[20:0];
      active       <= goal_active;
      unique case (op_r)
        mgpt_pkg::OP_SET_GLOBAL: begin
          if (!owned_r) begin
            goal_active  <= 1'b1;
            owner_id     <= id_r;
            goal_px      <= ax_r;
            goal_py      <= ay_r;
            goal_angle   <= wrap_set;
            goal_x       <= ax_r;
            goal_y       <= ay_r;
            goal_heading <= wrap_set[20:0];
            active       <= 1'b1;
          end
        end
        mgpt_pkg::OP_SET_LOCAL: begin
          if (!owned_r) begin
            goal_active  <= 1'b1;
            owner_id     <= id_r;
            goal_px      <= mgpt_pkg::sat32(40'(p0) - 40'(p1) + 40'(px_r));
            goal_py      <= mgpt_pkg::sat32(40'(p2) + 40'(p3) + 40'(py_r));
            goal_angle   <= wrap_set;
            goal_x       <= mgpt_pkg::sat32(40'(p0) - 40'(p1) + 40'(px_r));
            goal_y       <= mgpt_pkg::sat32(40'(p2) + 40'(p3) + 40'(py_r));
            goal_heading <= wrap_set[20:0];
            active       <= 1'b1;
          end
        end
        mgpt_pkg::OP_PASSED: begin
          if (passed) begin
            goal_active <= 1'b0;
            flag        <= 1'b1;
            active      <= 1'b0;
          end
        end
        mgpt_pkg::OP_ALIGNED:
          flag <= goal_active && (md_goal_ph < margin_w);
        mgpt_pkg::OP_PARALLEL:
          flag <= goal_active && (md_par > pi_minus_margin || md_par < margin_w);
        mgpt_pkg::OP_LOCAL_FRAME: begin
          goal_x       <= mgpt_pkg::sat32(40'(p0) + 40'(p1));
          goal_y       <= mgpt_pkg::sat32(40'(p2) - 40'(p3));
          goal_heading <= mgpt_pkg::sat21(24'(goal_angle) - 24'(ph_r));
        end
        mgpt_pkg::OP_JUMP: begin
          goal_px <= mgpt_pkg::sat32(40'(goal_px) + 40'(ax_r));
          goal_py <= mgpt_pkg::sat32(40'(goal_py) + 40'(ay_r));
          goal_x  <= mgpt_pkg::sat32(40'(goal_px) + 40'(ax_r));
          goal_y  <= mgpt_pkg::sat32(40'(goal_py) + 40'(ay_r));
        end
        mgpt_pkg::OP_SHIFT: begin
          goal_px <= mgpt_pkg::sat32(40'(goal_px) + 40'(p0));
          goal_py <= mgpt_pkg::sat32(40'(goal_py) + 40'(p1));
          goal_x  <= mgpt_pkg::sat32(40'(goal_px) + 40'(p0));
          goal_y  <= mgpt_pkg::sat32(40'(goal_py) + 40'(p1));
        end
        default: ;
      endcase
    end
  end

  // no request is taken while a result is pending
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while result pending");

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("sequencer stayed idle after accept");

  // a taken result is not shown again
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated");

  // only the test opcodes raise the flag
  a_flag_ops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && flag) |-> (op_r == mgpt_pkg::OP_PASSED || op_r == mgpt_pkg::OP_ALIGNED ||
                             op_r == mgpt_pkg::OP_PARALLEL))
    else $error("flag set by non-test opcode");

  // a passed result always deactivates the goal
  a_passed_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && flag && op_r == mgpt_pkg::OP_PASSED) |-> (!active && !goal_active))
    else $error("passed goal still active");

endmodule
